// ===== design/jsu_pkg.sv =====
// Shared types, codes and helper functions for the JSON string unescaper.
`timescale 1ns / 1ps

package jsu_pkg;

    // Result status codes.
    localparam logic [1:0] ST_DATA  = 2'd0;
    localparam logic [1:0] ST_CLOSE = 2'd1;
    localparam logic [1:0] ST_ERR   = 2'd2;

    // Quote kinds recorded at the opening byte.
    localparam logic [1:0] QK_NONE   = 2'd0;
    localparam logic [1:0] QK_DOUBLE = 2'd1;
    localparam logic [1:0] QK_SINGLE = 2'd2;
    localparam logic [1:0] QK_OTHER  = 2'd3;

    // Character codes used by the parser.
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_U      = 8'h75;

    // Default depth of the result queue; it must be at least six.
    localparam int unsigned RESULT_DEPTH = 8;

    // Largest number of results one input byte can cause.
    localparam int unsigned MAX_RESULTS = 3;

    typedef enum logic [3:0] {
        MODE_IDLE = 4'b0001,
        MODE_STR  = 4'b0010,
        MODE_ESC  = 4'b0100,
        MODE_HEX  = 4'b1000
    } mode_t;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] status;
        logic       last;
    } result_t;

    // Group of results written into the queue in one cycle.
    typedef struct packed {
        logic [1:0] count;
        result_t    r2;
        result_t    r1;
        result_t    r0;
    } push_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_val(input logic [7:0] c);
        hex_t h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h.value = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            h.value = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            h.value = 4'(c - 8'h37);
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    // Single-byte escapes; zero means the escape is dropped.
    function automatic logic [7:0] esc_map(input logic [7:0] c);
        logic [7:0] m;
        case (c)
            CH_BSLASH: m = CH_BSLASH;
            CH_SLASH:  m = CH_SLASH;
            CH_DQUOTE: m = CH_DQUOTE;
            CH_SQUOTE: m = CH_SQUOTE;
            8'h62:     m = 8'd8;
            8'h66:     m = 8'd12;
            8'h72:     m = 8'd13;
            8'h6E:     m = 8'd10;
            8'h74:     m = 8'd9;
            default:   m = 8'd0;
        endcase
        return m;
    endfunction

endpackage

// ===== design/json_string_unescape_utf8.sv =====
// Top level of the streaming JSON string unescaper with UTF-8 encoding of \u escapes.
`timescale 1ns / 1ps

// Usage: raw text enters one byte per transaction on the input channel
// (in_valid / in_stall), with start_req marking the opening quote of a new
// string and buffer_end marking the final byte of the buffer. Decoded bytes,
// the clean-close marker and error markers leave on the output channel
// (out_valid / out_stall) as one result per transaction; last flags the final
// result caused by one input byte.
// An accepted byte is held in the input register, then decoded in the following
// cycle and written into the result queue.
// Throughput: one input byte per cycle while each byte causes at most one
// result. A \u escape may expand into three results; the result queue absorbs
// such bursts, and in_stall rises while the queue holds more than
// FIFO_DEPTH - 6 results, which is what limits the input rate when the
// receiver is slow or output bursts pile up.
// When the receiver raises out_stall, the head result is held unchanged and
// the queue keeps filling until in_stall backs up the sender.
// Reset empties the input register and the queue and returns the parser to
// idle, waiting for a start byte.
module json_string_unescape_utf8
    import jsu_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = RESULT_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       start_req,
    input  logic       buffer_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic [1:0] status,
    output logic       last
);

    localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

    // Room is kept for the byte in the input register plus one more.
    localparam int unsigned STALL_LEVEL = FIFO_DEPTH - 2 * MAX_RESULTS;

    logic          load;
    logic          pop;
    logic          item_pending;
    push_t         push;
    result_t       head;
    logic [CW-1:0] fill;

    assign in_stall = (fill > CW'(STALL_LEVEL));
    assign load     = in_valid && !in_stall;
    assign pop      = out_valid && !out_stall;

    jsu_decode u_decode
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .in_byte      (in_byte),
        .start_req    (start_req),
        .buffer_end   (buffer_end),
        .item_pending (item_pending),
        .push         (push)
    );

    jsu_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .head      (head),
        .not_empty (out_valid),
        .fill      (fill)
    );

    assign out_byte = head.data;
    assign status   = head.status;
    assign last     = head.last;

    // The queue never overflows.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill <= CW'(FIFO_DEPTH))
    else $error("result queue overflow");

    // An accepted transaction is decoded in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        load |=> item_pending)
    else $error("accepted byte not held in input register");

    // Close and error markers always end the results of their byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_DATA) |-> (last && out_byte == 8'd0))
    else $error("marker result not last or carries data");

    // Nothing is written into the queue without a pending byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        !item_pending |-> (push.count == 2'd0))
    else $error("results pushed without a pending byte");

endmodule

// ===== design/jsu_decode.sv =====
// Input register, parser state and single-pass decode of one byte into results.
`timescale 1ns / 1ps

module jsu_decode
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  logic [7:0] in_byte,
    input  logic       start_req,
    input  logic       buffer_end,
    output logic       item_pending,
    output push_t      push
);

    logic        pend_reg;
    logic [7:0]  byte_reg;
    logic        start_reg;
    logic        bend_reg;

    mode_t       mode_reg,  mode_next;
    logic [1:0]  quote_reg, quote_next;
    logic [15:0] accum_reg, accum_next;
    logic [2:0]  left_reg,  left_next;

    logic [1:0]  close_kind;
    hex_t        hx;
    logic [7:0]  esc_byte;
    logic [15:0] cp;

    // The input register is written only on an accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg  <= in_byte;
            start_reg <= start_req;
            bend_reg  <= buffer_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            quote_reg <= QK_NONE;
            accum_reg <= 16'd0;
            left_reg  <= 3'd0;
        end
        else
        begin
            mode_reg  <= mode_next;
            quote_reg <= quote_next;
            accum_reg <= accum_next;
            left_reg  <= left_next;
        end
    end

    assign close_kind = (byte_reg == CH_DQUOTE) ? QK_DOUBLE :
                        (byte_reg == CH_SQUOTE) ? QK_SINGLE : QK_NONE;
    assign hx         = hex_val(byte_reg);
    assign esc_byte   = esc_map(byte_reg);
    assign cp         = {accum_reg[11:0], hx.value};

    always_comb
    begin
        mode_next  = mode_reg;
        quote_next = quote_reg;
        accum_next = accum_reg;
        left_next  = left_reg;
        push       = '0;

        if (pend_reg)
        begin
            if (start_reg)
            begin
                accum_next = 16'd0;
                left_next  = 3'd0;
                if (bend_reg)
                begin
                    mode_next        = MODE_IDLE;
                    quote_next       = QK_NONE;
                    push.count       = 2'd1;
                    push.r0.status   = ST_ERR;
                    push.r0.last     = 1'b1;
                end
                else
                begin
                    mode_next  = MODE_STR;
                    quote_next = (byte_reg == CH_DQUOTE) ? QK_DOUBLE :
                                 (byte_reg == CH_SQUOTE) ? QK_SINGLE : QK_OTHER;
                end
            end
            else
            begin
                case (mode_reg)
                    MODE_IDLE:
                    begin
                    end
                    MODE_STR:
                    begin
                        if (close_kind != QK_NONE && close_kind == quote_reg)
                        begin
                            mode_next      = MODE_IDLE;
                            quote_next     = QK_NONE;
                            accum_next     = 16'd0;
                            left_next      = 3'd0;
                            push.count     = 2'd1;
                            push.r0.status = ST_CLOSE;
                            push.r0.last   = 1'b1;
                        end
                        else if (bend_reg)
                        begin
                            mode_next      = MODE_IDLE;
                            quote_next     = QK_NONE;
                            accum_next     = 16'd0;
                            left_next      = 3'd0;
                            push.count     = 2'd1;
                            push.r0.status = ST_ERR;
                            push.r0.last   = 1'b1;
                        end
                        else if (byte_reg == CH_BSLASH)
                        begin
                            mode_next = MODE_ESC;
                        end
                        else
                        begin
                            push.count   = 2'd1;
                            push.r0.data = byte_reg;
                            push.r0.last = 1'b1;
                        end
                    end
                    MODE_ESC:
                    begin
                        if (bend_reg)
                        begin
                            mode_next      = MODE_IDLE;
                            quote_next     = QK_NONE;
                            accum_next     = 16'd0;
                            left_next      = 3'd0;
                            push.count     = 2'd1;
                            push.r0.status = ST_ERR;
                            push.r0.last   = 1'b1;
                        end
                        else if (byte_reg == CH_U)
                        begin
                            mode_next  = MODE_HEX;
                            left_next  = 3'd4;
                            accum_next = 16'd0;
                        end
                        else
                        begin
                            mode_next = MODE_STR;
                            if (esc_byte != 8'd0)
                            begin
                                push.count   = 2'd1;
                                push.r0.data = esc_byte;
                                push.r0.last = 1'b1;
                            end
                        end
                    end
                    MODE_HEX:
                    begin
                        if (bend_reg || !hx.ok)
                        begin
                            mode_next      = MODE_IDLE;
                            quote_next     = QK_NONE;
                            accum_next     = 16'd0;
                            left_next      = 3'd0;
                            push.count     = 2'd1;
                            push.r0.status = ST_ERR;
                            push.r0.last   = 1'b1;
                        end
                        else if (left_reg != 3'd1)
                        begin
                            accum_next = cp;
                            left_next  = left_reg - 3'd1;
                        end
                        else
                        begin
                            // Fourth digit: encode the code point as UTF-8.
                            mode_next  = MODE_STR;
                            accum_next = 16'd0;
                            left_next  = 3'd0;
                            if (cp[15:7] == 9'd0)
                            begin
                                push.count   = 2'd1;
                                push.r0.data = {1'b0, cp[6:0]};
                                push.r0.last = 1'b1;
                            end
                            else if (cp[15:11] == 5'd0)
                            begin
                                push.count   = 2'd2;
                                push.r0.data = {3'b110, cp[10:6]};
                                push.r1.data = {2'b10, cp[5:0]};
                                push.r1.last = 1'b1;
                            end
                            else
                            begin
                                push.count   = 2'd3;
                                push.r0.data = {4'b1110, cp[15:12]};
                                push.r1.data = {2'b10, cp[11:6]};
                                push.r2.data = {2'b10, cp[5:0]};
                                push.r2.last = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        mode_next      = MODE_IDLE;
                        quote_next     = QK_NONE;
                        accum_next     = 16'd0;
                        left_next      = 3'd0;
                        push.count     = 2'd1;
                        push.r0.status = ST_ERR;
                        push.r0.last   = 1'b1;
                    end
                endcase
            end
        end
    end

    assign item_pending = pend_reg;

endmodule

// ===== design/jsu_fifo.sv =====
// Result queue that takes up to three results per cycle and hands out one.
`timescale 1ns / 1ps

module jsu_fifo
    import jsu_pkg::*;
#(
    parameter int unsigned DEPTH = RESULT_DEPTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  push_t                      push,
    input  logic                       pop,
    output result_t                    head,
    output logic                       not_empty,
    output logic [$clog2(DEPTH+1)-1:0] fill
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    result_t        mem_reg [DEPTH];
    logic [PW-1:0]  wr_reg, wr_next;
    logic [PW-1:0]  rd_reg, rd_next;
    logic [CW-1:0]  fill_reg, fill_next;

    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] base,
                                               input logic [1:0]    off);
        logic [PW:0] sum;
        sum = {1'b0, base} + (PW+1)'(off);
        if (sum >= (PW+1)'(DEPTH))
        begin
            sum = sum - (PW+1)'(DEPTH);
        end
        return sum[PW-1:0];
    endfunction

    assign wr_next   = wrap_add(wr_reg, push.count);
    assign rd_next   = pop ? wrap_add(rd_reg, 2'd1) : rd_reg;
    assign fill_next = fill_reg + CW'(push.count) - CW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_reg] <= push.r0;
        end
        if (push.count > 2'd1)
        begin
            mem_reg[wrap_add(wr_reg, 2'd1)] <= push.r1;
        end
        if (push.count > 2'd2)
        begin
            mem_reg[wrap_add(wr_reg, 2'd2)] <= push.r2;
        end
    end

    assign head      = mem_reg[rd_reg];
    assign not_empty = (fill_reg != '0);
    assign fill      = fill_reg;

endmodule

// ===== verif/json_string_unescape_utf8_tb.sv =====
// Self-checking testbench for the streaming JSON string unescaper with UTF-8 output.
`timescale 1ns / 1ps

// The testbench feeds quoted text into the unescaper one byte per input
// transaction. As each byte is accepted, a behavioral decoder in this file
// works out the results that the byte must cause and queues them. A checker
// process pops the oldest queued result for every output transaction and
// compares data, status and the last flag.
//
// Both channels use valid/stall handshakes. The sender inserts random gaps
// and the receiver raises out_stall at random. A quiet stretch turns both off.
// One test holds the receiver off for a long time, so the result queue fills
// up and the block has to push back on its input.
module json_string_unescape_utf8_tb;
    import jsu_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_BYTES  = 8;
    localparam int B2B_BYTES     = 10;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 4;

    // Escape letters and other characters that the decoder and the stimulus use.
    localparam logic [7:0] CH_LC_B  = "b";
    localparam logic [7:0] CH_LC_F  = "f";
    localparam logic [7:0] CH_LC_R  = "r";
    localparam logic [7:0] CH_LC_N  = "n";
    localparam logic [7:0] CH_LC_T  = "t";
    localparam logic [7:0] CH_LC_X  = "x";
    localparam logic [7:0] CH_LC_Z  = "z";
    localparam logic [7:0] CH_LC_A  = "a";
    localparam logic [7:0] CH_UC_A  = "A";
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_TAB   = 8'd9;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte    = 8'h00;
    logic       start_req  = 1'b0;
    logic       buffer_end = 1'b0;
    logic       out_valid;
    logic       out_stall  = 1'b0;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last;

    json_string_unescape_utf8 u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .start_req  (start_req),
        .buffer_end (buffer_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .status     (status),
        .last       (last)
    );

    always #(CLK_HALF) clk = ~clk;

    // Run bookkeeping.
    int cycle_count     = 0;
    int mismatches      = 0;
    int bytes_sent      = 0;
    int bytes_used      = 0;
    int results_checked = 0;
    int closes_seen     = 0;
    int errors_seen     = 0;

    // When steady is set, neither side inserts random gaps or stalls.
    bit steady = 1'b0;

    // A test asks for a long receiver hold-off by bumping hold_requests; the
    // receiver process serves each request and counts the hold-off itself.
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;

    // Behavioral copy of the parser state.
    mode_t       parse_mode  = MODE_IDLE;
    logic [1:0]  open_kind   = QK_NONE;
    logic [15:0] code_point  = 16'd0;
    logic [2:0]  digits_left = 3'd0;

    // Results that accepted input bytes must still cause, oldest first.
    result_t expected_results[$];

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still expected",
                     cycle_count, expected_results.size());
            $display("simulation failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    // Bit 4 flags a valid hex digit, bits 3:0 carry its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return {1'b1, 4'(c - "0")};
        if (c >= "a" && c <= "f")
            return {1'b1, 4'(c - "a" + 8'd10)};
        if (c >= "A" && c <= "F")
            return {1'b1, 4'(c - "A" + 8'd10)};
        return 5'd0;
    endfunction

    // Byte produced by a backslash escape; zero means the escape is dropped.
    function automatic logic [7:0] escape_byte(input logic [7:0] c);
        case (c)
            CH_BSLASH: return CH_BSLASH;
            CH_SLASH:  return CH_SLASH;
            CH_DQUOTE: return CH_DQUOTE;
            CH_SQUOTE: return CH_SQUOTE;
            CH_LC_B:   return CH_BS;
            CH_LC_F:   return CH_FF;
            CH_LC_R:   return CH_CR;
            CH_LC_N:   return CH_LF;
            CH_LC_T:   return CH_TAB;
            default:   return CH_NUL;
        endcase
    endfunction

    function automatic void reset_parser();
        parse_mode  = MODE_IDLE;
        open_kind   = QK_NONE;
        code_point  = 16'd0;
        digits_left = 3'd0;
    endfunction

    // Advances the parser copy by one accepted byte and queues its results.
    // used is cleared when the byte is ignored because no string is open.
    task automatic decode_byte(input logic [7:0] c, input logic s, input logic e,
                               output bit used);
        result_t    r[3];
        int         n;
        logic [1:0] kind;
        logic [4:0] nib;
        logic [7:0] mapped;
        n    = 0;
        used = 1'b1;
        if (s)
        begin
            // A start byte always opens a fresh string, abandoning any open one.
            reset_parser();
            open_kind  = (c == CH_DQUOTE) ? QK_DOUBLE :
                         (c == CH_SQUOTE) ? QK_SINGLE : QK_OTHER;
            parse_mode = MODE_STR;
            if (e)
            begin
                reset_parser();
                r[n++] = '{data: 8'd0, status: ST_ERR, last: 1'b0};
            end
        end
        else if (parse_mode == MODE_IDLE)
        begin
            used = 1'b0;
        end
        else if (parse_mode == MODE_STR)
        begin
            kind = (c == CH_DQUOTE) ? QK_DOUBLE : (c == CH_SQUOTE) ? QK_SINGLE : QK_NONE;
            // A matching quote closes the string even on the last buffer byte.
            if (kind != QK_NONE && kind == open_kind)
            begin
                reset_parser();
                r[n++] = '{data: 8'd0, status: ST_CLOSE, last: 1'b0};
            end
            else if (e)
            begin
                reset_parser();
                r[n++] = '{data: 8'd0, status: ST_ERR, last: 1'b0};
            end
            else if (c == CH_BSLASH)
            begin
                parse_mode = MODE_ESC;
            end
            else
            begin
                r[n++] = '{data: c, status: ST_DATA, last: 1'b0};
            end
        end
        else if (e)
        begin
            // The buffer ran out in the middle of an escape.
            reset_parser();
            r[n++] = '{data: 8'd0, status: ST_ERR, last: 1'b0};
        end
        else if (parse_mode == MODE_ESC)
        begin
            if (c == CH_U)
            begin
                parse_mode  = MODE_HEX;
                digits_left = 3'd4;
                code_point  = 16'd0;
            end
            else
            begin
                parse_mode = MODE_STR;
                mapped     = escape_byte(c);
                if (mapped != CH_NUL)
                    r[n++] = '{data: mapped, status: ST_DATA, last: 1'b0};
            end
        end
        else
        begin
            nib = hex_digit(c);
            if (!nib[4])
            begin
                reset_parser();
                r[n++] = '{data: 8'd0, status: ST_ERR, last: 1'b0};
            end
            else
            begin
                code_point  = {code_point[11:0], nib[3:0]};
                digits_left = digits_left - 3'd1;
                if (digits_left == 3'd0)
                begin
                    // Encode the finished code point as one to three UTF-8 bytes.
                    parse_mode = MODE_STR;
                    if (code_point < 16'd128)
                    begin
                        r[n++] = '{data: code_point[7:0], status: ST_DATA, last: 1'b0};
                    end
                    else if (code_point < 16'd2048)
                    begin
                        r[n++] = '{data: {3'b110, code_point[10:6]}, status: ST_DATA,
                                   last: 1'b0};
                        r[n++] = '{data: {2'b10, code_point[5:0]}, status: ST_DATA,
                                   last: 1'b0};
                    end
                    else
                    begin
                        r[n++] = '{data: {4'b1110, code_point[15:12]}, status: ST_DATA,
                                   last: 1'b0};
                        r[n++] = '{data: {2'b10, code_point[11:6]}, status: ST_DATA,
                                   last: 1'b0};
                        r[n++] = '{data: {2'b10, code_point[5:0]}, status: ST_DATA,
                                   last: 1'b0};
                    end
                    code_point = 16'd0;
                end
            end
        end
        for (int i = 0; i < n; i++)
        begin
            r[i].last = (i == n - 1);
            expected_results.insert(expected_results.size(), r[i]);
        end
    endtask

    // Offers one byte and waits for the input transaction to complete. valid
    // stays high afterwards so that back-to-back bytes leave no gap.
    task automatic send_byte(input logic [7:0] b, input logic s, input logic e);
        bit used;
        while (!steady && $urandom_range(0, 99) < 16)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_byte    <= b;
        start_req  <= s;
        buffer_end <= e;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        decode_byte(b, s, e, used);
        bytes_sent++;
        if (used)
            bytes_used++;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
        if (nib < 4'd10)
            return CH_ZERO + 8'(nib);
        return (upper ? CH_UC_A : CH_LC_A) + 8'(nib) - 8'd10;
    endfunction

    // Sends a backslash-u escape for the given code point, digits in mixed case.
    task automatic send_unicode(input logic [15:0] cp);
        send_byte(CH_BSLASH, 1'b0, 1'b0);
        send_byte(CH_U, 1'b0, 1'b0);
        for (int i = 3; i >= 0; i--)
            send_byte(hex_char(cp[i*4 +: 4], 1'($urandom_range(0, 1))), 1'b0, 1'b0);
    endtask

    // Lets every expected result arrive, then keeps waiting so that a byte
    // that causes no result has left the pipeline as well.
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Receiver: random stalls, quiet stretches, and long hold-offs on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall    <= 1'b0;
            hold_left    <= 0;
            holds_served <= 0;
        end
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_requests != holds_served)
        begin
            out_stall    <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end
        else if (steady)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < 16);
        end
    end

    // Checker: every output transaction is compared with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_checked++;
            if (status == ST_CLOSE)
                closes_seen++;
            if (status == ST_ERR)
                errors_seen++;
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result byte %02h status %0d last %0b",
                                          out_byte, status, last));
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_byte !== want.data)
                    report_mismatch($sformatf("byte %02h, expected %02h",
                                              out_byte, want.data));
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              status, want.status));
                if (last !== want.last)
                    report_mismatch($sformatf("last %0b, expected %0b", last, want.last));
            end
        end
    end

    // Bytes outside a string, plain data, both quote kinds and a close that
    // falls on the final buffer byte.
    task automatic test_plain_strings();
        send_byte(CH_LC_A, 1'b0, 1'b0);
        send_byte(CH_NUL, 1'b0, 1'b1);
        send_byte(CH_DQUOTE, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(CH_SQUOTE, 1'b0, 1'b0);
        send_byte(CH_DQUOTE, 1'b0, 1'b0);
        send_byte(CH_SQUOTE, 1'b1, 1'b0);
        send_byte(CH_DQUOTE, 1'b0, 1'b0);
        send_byte(CH_SQUOTE, 1'b0, 1'b1);
        drain();
    endtask

    // Every single-byte escape, dropped escapes and code points at the edges
    // of the one, two and three byte encodings.
    task automatic test_escapes();
        logic [7:0] letters[9];
        letters = '{CH_BSLASH, CH_SLASH, CH_DQUOTE, CH_SQUOTE,
                    CH_LC_B, CH_LC_F, CH_LC_R, CH_LC_N, CH_LC_T};
        send_byte(CH_DQUOTE, 1'b1, 1'b0);
        foreach (letters[i])
        begin
            send_byte(CH_BSLASH, 1'b0, 1'b0);
            send_byte(letters[i], 1'b0, 1'b0);
        end
        send_byte(CH_BSLASH, 1'b0, 1'b0);
        send_byte(CH_LC_X, 1'b0, 1'b0);
        send_byte(CH_BSLASH, 1'b0, 1'b0);
        send_byte(CH_NUL, 1'b0, 1'b0);
        send_unicode(16'h007F);
        send_unicode(16'h0080);
        send_unicode(16'h07FF);
        send_unicode(16'h0800);
        send_byte(CH_DQUOTE, 1'b0, 1'b0);
        drain();
    endtask

    // Buffer ends on a start byte and in the string, escape and hex states, a bad
    // hex digit, an opener that is not a quote, and a restart inside an open string.
    task automatic test_error_paths();
        send_byte(CH_DQUOTE, 1'b1, 1'b1);
        send_byte(CH_LC_A, 1'b1, 1'b0);
        send_byte(CH_DQUOTE, 1'b0, 1'b0);
        send_byte(CH_SQUOTE, 1'b0, 1'b0);
        send_byte(CH_LC_X, 1'b0, 1'b1);
        send_byte(CH_DQUOTE, 1'b1, 1'b0);
        send_byte(CH_BSLASH, 1'b0, 1'b0);
        send_byte(CH_LC_N, 1'b0, 1'b1);
        send_byte(CH_SQUOTE, 1'b1, 1'b0);
        send_byte(CH_BSLASH, 1'b0, 1'b0);
        send_byte(CH_U, 1'b0, 1'b0);
        send_byte(CH_ZERO, 1'b0, 1'b0);
        send_byte(CH_ZERO, 1'b0, 1'b1);
        send_byte(CH_DQUOTE, 1'b1, 1'b0);
        send_byte(CH_BSLASH, 1'b0, 1'b0);
        send_byte(CH_U, 1'b0, 1'b0);
        send_byte(CH_LC_Z, 1'b0, 1'b0);
        send_byte(CH_DQUOTE, 1'b1, 1'b0);
        send_byte(CH_LC_A, 1'b0, 1'b0);
        send_byte(CH_SQUOTE, 1'b1, 1'b0);
        send_byte(CH_LC_B, 1'b0, 1'b0);
        send_byte(CH_SQUOTE, 1'b0, 1'b0);
        drain();
    endtask

    // Three byte code points back to back while the receiver is held off, so
    // the result queue fills and the block stalls its input.
    task automatic test_backpressure();
        send_byte(CH_DQUOTE, 1'b1, 1'b0);
        hold_requests++;
        repeat (3)
            send_unicode(16'(($urandom_range(0, 16'hF7FF) + 16'h0800)));
        send_byte(CH_DQUOTE, 1'b0, 1'b0);
        drain();
    endtask

    // One mostly well-formed string with random content; a few segments break
    // it on purpose with a restart, an early buffer end or a bad hex digit.
    task automatic random_string();
        int          pick;
        int          segs;
        logic [7:0]  opener;
        logic [7:0]  bad;
        logic [4:0]  probe;
        if ($urandom_range(0, 9) == 0)
            send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
        pick   = $urandom_range(0, 9);
        opener = (pick < 5) ? CH_DQUOTE : (pick < 9) ? CH_SQUOTE : 8'($urandom_range(0, 255));
        send_byte(opener, 1'b1, $urandom_range(0, 39) == 0);
        segs = $urandom_range(0, 6);
        repeat (segs)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            else if (pick < 60)
            begin
                send_byte(CH_BSLASH, 1'b0, 1'b0);
                case ($urandom_range(0, 10))
                    0:  send_byte(CH_BSLASH, 1'b0, 1'b0);
                    1:  send_byte(CH_SLASH, 1'b0, 1'b0);
                    2:  send_byte(CH_DQUOTE, 1'b0, 1'b0);
                    3:  send_byte(CH_SQUOTE, 1'b0, 1'b0);
                    4:  send_byte(CH_LC_B, 1'b0, 1'b0);
                    5:  send_byte(CH_LC_F, 1'b0, 1'b0);
                    6:  send_byte(CH_LC_R, 1'b0, 1'b0);
                    7:  send_byte(CH_LC_N, 1'b0, 1'b0);
                    8:  send_byte(CH_LC_T, 1'b0, 1'b0);
                    9:  send_byte(CH_NUL, 1'b0, 1'b0);
                    default: send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                endcase
            end
            else if (pick < 85)
            begin
                case ($urandom_range(0, 2))
                    0:       send_unicode(16'($urandom_range(0, 127)));
                    1:       send_unicode(16'($urandom_range(128, 2047)));
                    default: send_unicode(16'($urandom_range(2048, 65535)));
                endcase
            end
            else if (pick < 90)
            begin
                send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            end
            else if (pick < 95)
            begin
                send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            end
            else
            begin
                send_byte(CH_BSLASH, 1'b0, 1'b0);
                send_byte(CH_U, 1'b0, 1'b0);
                do
                begin
                    bad   = 8'($urandom_range(0, 255));
                    probe = hex_digit(bad);
                end
                while (probe[4]);
                send_byte(bad, 1'b0, 1'b0);
            end
        end
        send_byte(opener, 1'b0, $urandom_range(0, 3) == 0);
    endtask

    task automatic test_random_strings();
        int goal;
        goal = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < goal)
            random_string();
        drain();
    endtask

    // A stretch with no gaps and no stalls on either side.
    task automatic test_back_to_back();
        int goal;
        goal   = bytes_sent + B2B_BYTES;
        steady = 1'b1;
        while (bytes_sent < goal)
            random_string();
        drain();
        steady = 1'b0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_strings();
        test_escapes();
        test_error_paths();
        test_backpressure();
        test_back_to_back();
        test_random_strings();

        $display("Covered: %0d bytes sent (%0d inside strings), %0d results checked",
                 bytes_sent, bytes_used, results_checked);
        $display("Covered: %0d clean closes, %0d error results, %0d mismatches",
                 closes_seen, errors_seen, mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
